### rtl/core/rrpp_pkg.sv
// ----------------------------------------------------------------------------
// rrpp_pkg
// Shared widths, codes, constants and types of the region palette painter.
// ----------------------------------------------------------------------------
package rrpp_pkg;

	localparam int STATE_W         = 48;
	localparam int CHUNK_W         = 16;
	localparam int MULT_W          = 35;
	localparam int DRAW_W          = 3;
	localparam int CNT_W           = 17;
	localparam int LABEL_W         = 16;
	localparam int CMD_W           = 2;
	localparam int REGION_CNT_W    = 13;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int BYTE_W          = 8;
	localparam int RGB_W           = 24;
	localparam int PAL_ENT_W       = 24;
	localparam int PAL_W           = 3 * CFG_DATA_W;
	localparam int MAX_REGIONS_DEF = 4096;

	localparam logic [MULT_W-1:0]  LCG_MULT   = 35'h5DEECE66D;
	localparam logic [STATE_W-1:0] LCG_ADD    = 48'hB;
	localparam logic [BYTE_W-1:0]  ALPHA_FULL = 8'hFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_PIXEL  = 2'd0,
		CMD_FRAME  = 2'd1,
		CMD_RESEED = 2'd2
	} cmd_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEED         = 3'd0,
		REG_REGION_COUNT = 3'd1,
		REG_BACKGROUND   = 3'd2,
		REG_PAL_LOW      = 3'd3,
		REG_PAL_MID      = 3'd4,
		REG_PAL_HIGH     = 3'd5
	} cfg_idx_e;

	typedef struct packed {
		logic start;
		logic load;
	} lcg_ctl_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DRAW_W-1:0] draw;
	} lcg_sts_t;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] alpha;
		logic [DRAW_W-1:0] last_draw;
		logic              label_error;
	} res_t;

endpackage

### rtl/core/rrpp_ifs.sv
// ----------------------------------------------------------------------------
// rrpp_ifs
// Valid/ready channels of the painter: command, result and register write.
// ----------------------------------------------------------------------------
interface rrpp_req_if;
	logic                          valid;
	logic                          ready;
	logic [rrpp_pkg::CMD_W-1:0]    command;
	logic [rrpp_pkg::LABEL_W-1:0]  label;

	modport source (output valid, output command, output label, input ready);
	modport sink   (input valid, input command, input label, output ready);
endinterface

interface rrpp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rrpp_pkg::BYTE_W-1:0]   red;
	logic [rrpp_pkg::BYTE_W-1:0]   green;
	logic [rrpp_pkg::BYTE_W-1:0]   blue;
	logic [rrpp_pkg::BYTE_W-1:0]   alpha;
	logic [rrpp_pkg::DRAW_W-1:0]   last_draw;
	logic                          label_error;

	modport source (output valid, output red, output green, output blue, output alpha,
		output last_draw, output label_error, input ready);
	modport sink   (input valid, input red, input green, input blue, input alpha,
		input last_draw, input label_error, output ready);
endinterface

interface rrpp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rrpp_pkg::CFG_IDX_W-1:0]  index;
	logic [rrpp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/rrpp_ram.sv
// ----------------------------------------------------------------------------
// rrpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrpp_ram #(
	parameter int  WIDTH = 3,
	parameter int  DEPTH = 4096,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/rrpp_lcg.sv
// ----------------------------------------------------------------------------
// rrpp_lcg
// 48-bit linear congruential generator; one 16-bit slice of the state is
// multiplied and accumulated per cycle, low, middle and high slice in turn.
// ----------------------------------------------------------------------------
module rrpp_lcg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrpp_pkg::lcg_ctl_t            ctl,
	input  logic [rrpp_pkg::STATE_W-1:0]  seed,
	output rrpp_pkg::lcg_sts_t            sts
);
	import rrpp_pkg::*;

	typedef enum logic [1:0] {
		PH_LO,
		PH_MID,
		PH_HI
	} phase_t;

	phase_t                      phase_q;
	logic                        busy_q;
	logic [STATE_W-1:0]          state_q;
	logic [STATE_W-1:0]          acc_q;
	logic [CHUNK_W-1:0]          chunk;
	logic [CHUNK_W+MULT_W-1:0]   prod;
	logic [STATE_W-1:0]          term;
	logic [STATE_W-1:0]          acc_in;
	logic [STATE_W-1:0]          sum;

	always_comb begin
		chunk = state_q[CHUNK_W-1:0];
		term  = '0;
		prod  = (CHUNK_W+MULT_W)'(chunk) * (CHUNK_W+MULT_W)'(LCG_MULT);
		case (phase_q)
			PH_LO: begin
				chunk = state_q[CHUNK_W-1:0];
				prod  = (CHUNK_W+MULT_W)'(chunk) * (CHUNK_W+MULT_W)'(LCG_MULT);
				term  = prod[STATE_W-1:0];
			end
			PH_MID: begin
				chunk = state_q[2*CHUNK_W-1:CHUNK_W];
				prod  = (CHUNK_W+MULT_W)'(chunk) * (CHUNK_W+MULT_W)'(LCG_MULT);
				term  = {prod[STATE_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
			end
			PH_HI: begin
				chunk = state_q[3*CHUNK_W-1:2*CHUNK_W];
				prod  = (CHUNK_W+MULT_W)'(chunk) * (CHUNK_W+MULT_W)'(LCG_MULT);
				term  = {prod[STATE_W-2*CHUNK_W-1:0], {(2*CHUNK_W){1'b0}}};
			end
			default: begin
				term = '0;
			end
		endcase
		acc_in = (phase_q == PH_LO) ? LCG_ADD : acc_q;
		sum    = acc_in + term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_LO;
			state_q <= '0;
		end else if (ctl.load) begin
			busy_q  <= 1'b0;
			phase_q <= PH_LO;
			state_q <= seed;
		end else if (ctl.start) begin
			busy_q  <= 1'b1;
			phase_q <= PH_LO;
		end else if (busy_q) begin
			unique case (phase_q)
				PH_LO:   phase_q <= PH_MID;
				PH_MID:  phase_q <= PH_HI;
				PH_HI: begin
					phase_q <= PH_LO;
					busy_q  <= 1'b0;
					state_q <= sum;
				end
				default: phase_q <= PH_LO;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			acc_q <= sum;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = busy_q && (phase_q == PH_HI);
	assign sts.draw = state_q[STATE_W-1:STATE_W-DRAW_W];

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q)
		else $error("generator started while a step is in progress");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.done && !ctl.load && !ctl.start) |=> !busy_q)
		else $error("generator still busy after final slice");

endmodule

### rtl/core/random_region_palette_painter.sv
// ----------------------------------------------------------------------------
// random_region_palette_painter
// Region-label to RGBA painter with a random palette choice per region.
// ----------------------------------------------------------------------------
// Usage: commands arrive on req (command, label), one result per command
// leaves on rsp, registers are written on cfg (always ready). The user must
// make cfg writes only while no command is outstanding; this is not enforced.
// A pixel command reads the region's colour index from RAM and returns the
// palette or background colour through the ST_PIX and ST_POST states.
// A new-frame command steps the generator once per region. ST_DRAW starts a
// step, the shared 16 x 35 multiply-accumulate unit works the low, middle and
// high state slices, and ST_WRITE stores the draw in the region RAM.
// A reseed or unused command answers through the ST_POST state.
// req.ready is high only while the sequencer is idle. A finished result sits
// in the rsp register; a receiver stall holds it and the following result
// waits in the sequencer until the register is free.
// Reset clears the generator, the last draw and all registers; the region
// RAM is not cleared and must be drawn by a frame before pixels read it.
// ----------------------------------------------------------------------------
module random_region_palette_painter #(
	parameter int MAX_REGIONS = rrpp_pkg::MAX_REGIONS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rrpp_req_if.sink   req,
	rrpp_rsp_if.source rsp,
	rrpp_cfg_if.sink   cfg
);
	import rrpp_pkg::*;

	localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIX,
		ST_DRAW,
		ST_WAIT,
		ST_WRITE,
		ST_POST
	} state_t;

	state_t                  state_q;
	logic [STATE_W-1:0]      seed_q;
	logic [REGION_CNT_W-1:0] region_count_q;
	logic [RGB_W-1:0]        background_q;
	logic [CFG_DATA_W-1:0]   pal_low_q;
	logic [CFG_DATA_W-1:0]   pal_mid_q;
	logic [CFG_DATA_W-1:0]   pal_high_q;
	logic [DRAW_W-1:0]       recent_q;
	logic [CNT_W-1:0]        k_q;
	logic                    err_q;
	logic                    bg_sel_q;
	res_t                    res_q;

	logic [CNT_W-1:0]        eff_count;
	logic [CNT_W-1:0]        region_ext;
	logic                    in_fire;
	logic                    out_free;
	logic                    label_err;
	logic [LABEL_W-1:0]      label_m1;
	logic [PAL_W-1:0]        pal_all;
	logic [PAL_ENT_W-1:0]    pal_entry;
	logic [DRAW_W-1:0]       ram_rdata;
	logic                    ram_we;
	logic                    ram_re;
	lcg_ctl_t                lcg_ctl;
	lcg_sts_t                lcg_sts;

	assign region_ext = CNT_W'(region_count_q);
	assign eff_count  = (region_ext > MAX_CNT) ? MAX_CNT : region_ext;
	assign in_fire    = req.valid && req.ready;
	assign out_free   = !rsp.valid || rsp.ready;
	assign label_err  = CNT_W'(req.label) > eff_count;
	assign label_m1   = req.label - LABEL_W'(1);
	assign pal_all    = {pal_high_q, pal_mid_q, pal_low_q};
	assign pal_entry  = pal_all[int'(ram_rdata) * PAL_ENT_W +: PAL_ENT_W];

	assign req.ready     = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign ram_re        = in_fire && (cmd_e'(req.command) == CMD_PIXEL);
	assign ram_we        = (state_q == ST_WRITE);
	assign lcg_ctl.start = (state_q == ST_DRAW) && (k_q != eff_count);
	assign lcg_ctl.load  = in_fire && (cmd_e'(req.command) == CMD_RESEED);

	rrpp_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lcg_ctl),
		.seed   (seed_q),
		.sts    (lcg_sts)
	);

	rrpp_ram #(
		.WIDTH (DRAW_W),
		.DEPTH (MAX_REGIONS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (k_q[AW-1:0]),
		.wdata (lcg_sts.draw),
		.re    (ram_re),
		.raddr (label_m1[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q         <= '0;
			region_count_q <= '0;
			background_q   <= '0;
			pal_low_q      <= '0;
			pal_mid_q      <= '0;
			pal_high_q     <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_e'(cfg.index))
				REG_SEED:         seed_q         <= cfg.data[STATE_W-1:0];
				REG_REGION_COUNT: region_count_q <= cfg.data[REGION_CNT_W-1:0];
				REG_BACKGROUND:   background_q   <= cfg.data[RGB_W-1:0];
				REG_PAL_LOW:      pal_low_q      <= cfg.data;
				REG_PAL_MID:      pal_mid_q      <= cfg.data;
				REG_PAL_HIGH:     pal_high_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			recent_q        <= '0;
			k_q             <= '0;
			rsp.valid       <= 1'b0;
			rsp.red         <= '0;
			rsp.green       <= '0;
			rsp.blue        <= '0;
			rsp.alpha       <= '0;
			rsp.last_draw   <= '0;
			rsp.label_error <= 1'b0;
			err_q           <= 1'b0;
			bg_sel_q        <= 1'b0;
			res_q           <= '0;
		end else begin
			if (rsp.valid && rsp.ready && (state_q != ST_POST)) begin
				rsp.valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (cmd_e'(req.command))
							CMD_PIXEL: begin
								err_q    <= label_err;
								bg_sel_q <= (req.label == '0) || label_err;
								state_q  <= ST_PIX;
							end
							CMD_FRAME: begin
								k_q     <= '0;
								state_q <= ST_DRAW;
							end
							default: begin
								res_q   <= {{(4*BYTE_W){1'b0}}, recent_q, 1'b0};
								state_q <= ST_POST;
							end
						endcase
					end
				end
				ST_PIX: begin
					if (bg_sel_q) begin
						res_q <= {background_q[BYTE_W-1:0],
							background_q[2*BYTE_W-1:BYTE_W],
							background_q[3*BYTE_W-1:2*BYTE_W],
							ALPHA_FULL, recent_q, err_q};
					end else begin
						res_q <= {pal_entry[BYTE_W-1:0],
							pal_entry[2*BYTE_W-1:BYTE_W],
							pal_entry[3*BYTE_W-1:2*BYTE_W],
							ALPHA_FULL, recent_q, err_q};
					end
					state_q <= ST_POST;
				end
				ST_DRAW: begin
					if (k_q == eff_count) begin
						res_q   <= {{(4*BYTE_W){1'b0}}, recent_q, 1'b0};
						state_q <= ST_POST;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (lcg_sts.done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					recent_q <= lcg_sts.draw;
					k_q      <= k_q + CNT_W'(1);
					state_q  <= ST_DRAW;
				end
				ST_POST: begin
					if (out_free) begin
						rsp.valid       <= 1'b1;
						rsp.red         <= res_q.red;
						rsp.green       <= res_q.green;
						rsp.blue        <= res_q.blue;
						rsp.alpha       <= res_q.alpha;
						rsp.last_draw   <= res_q.last_draw;
						rsp.label_error <= res_q.label_error;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (k_q < eff_count))
		else $error("region write beyond drawn count");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		lcg_sts.done |-> (state_q == ST_WAIT))
		else $error("generator step finished outside wait state");

	a_post_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_POST))
		else $error("result posted outside post state");

	a_err_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.label_error) |-> (rsp.alpha == ALPHA_FULL))
		else $error("flagged pixel without full alpha");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the random region palette painter. A built-in predictor mirrors
// the register file, the 48-bit generator and the region colour table, and
// queues one expected pixel per accepted command. Each response is checked
// field by field against the oldest queued pixel. Directed tests cover reset
// values, extreme registers, count saturation and empty frames. Random phases
// with random idling on both sides follow, plus a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import rrpp_pkg::*;

	localparam logic [STATE_W-1:0] GEN_MULT = 48'h5DEECE66D;
	localparam logic [STATE_W-1:0] GEN_INC  = 48'hB;
	localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
	localparam int REGION_LIMIT = MAX_REGIONS_DEF;
	localparam int RUN_LIMIT = 8000000;

	logic clk;
	logic arst_n;

	rrpp_req_if req_ch ();
	rrpp_rsp_if rsp_ch ();
	rrpp_cfg_if cfg_ch ();

	random_region_palette_painter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	logic [STATE_W-1:0]      seed_reg;
	logic [REGION_CNT_W-1:0] count_reg;
	logic [RGB_W-1:0]        bg_reg;
	logic [CFG_DATA_W-1:0]   pal_lo, pal_mid, pal_hi;
	logic [STATE_W-1:0]      gen_state;
	logic [DRAW_W-1:0]       colour_idx [0:REGION_LIMIT-1];
	logic [DRAW_W-1:0]       recent_draw;
	int                      drawn_regions;

	res_t expected_pixels [$];
	int   mismatches;
	int   rsp_hold_cycles;
	bit   steady_flow;

	always #4 clk = ~clk;

	function automatic int active_regions();
		return (count_reg > REGION_LIMIT) ? REGION_LIMIT : int'(count_reg);
	endfunction

	function automatic res_t paint_predict(logic [CMD_W-1:0] cmd, logic [LABEL_W-1:0] lbl);
		res_t r;
		int n;
		int base;
		logic [PAL_W-1:0] pal;
		r = '0;
		n = active_regions();
		pal = {pal_hi, pal_mid, pal_lo};
		case (cmd)
			CMD_PIXEL: begin
				r.alpha = 8'hFF;
				if (lbl == 0 || lbl > n) begin
					r.label_error = (lbl > n);
					{r.blue, r.green, r.red} = bg_reg;
				end else begin
					base = 24 * colour_idx[lbl - 1];
					r.red   = pal[base +: 8];
					r.green = pal[base + 8 +: 8];
					r.blue  = pal[base + 16 +: 8];
				end
			end
			CMD_FRAME: begin
				for (int k = 0; k < n; k++) begin
					gen_state = gen_state * GEN_MULT + GEN_INC;
					recent_draw = gen_state[STATE_W-1 -: DRAW_W];
					colour_idx[k] = recent_draw;
				end
				if (n > drawn_regions)
					drawn_regions = n;
			end
			CMD_RESEED: gen_state = seed_reg;
			default: ;
		endcase
		r.last_draw = recent_draw;
		return r;
	endfunction

	function automatic logic [LABEL_W-1:0] pick_label();
		int n, ok, sel;
		logic [LABEL_W-1:0] lbl;
		n = active_regions();
		ok = (drawn_regions < n) ? drawn_regions : n;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			lbl = (ok > 0) ? 16'($urandom_range(1, ok)) : 16'd0;
		else if (sel < 6)
			lbl = 16'd0;
		else if (sel < 8)
			lbl = 16'($urandom_range(n + 1, n + 8));
		else if (sel == 8)
			lbl = 16'($urandom_range(n + 1, 65535));
		else
			lbl = 16'($urandom);
		// keep clear of region entries no frame has written yet
		if (lbl >= 1 && lbl <= n && lbl > drawn_regions)
			lbl = (ok > 0) ? 16'($urandom_range(1, ok)) : 16'd0;
		return lbl;
	endfunction

	task automatic send_item(logic [CMD_W-1:0] cmd, logic [LABEL_W-1:0] lbl);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.command = cmd;
		req_ch.label = lbl;
		req_ch.valid = 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		expected_pixels.push_back(paint_predict(cmd, lbl));
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.index = idx;
		cfg_ch.data = val;
		cfg_ch.valid = 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_SEED:         seed_reg = val[STATE_W-1:0];
			REG_REGION_COUNT: count_reg = val[REGION_CNT_W-1:0];
			REG_BACKGROUND:   bg_reg = val[RGB_W-1:0];
			REG_PAL_LOW:      pal_lo = val;
			REG_PAL_MID:      pal_mid = val;
			REG_PAL_HIGH:     pal_hi = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic program_all(logic [STATE_W-1:0] sd, logic [REGION_CNT_W-1:0] cnt,
		logic [RGB_W-1:0] bg, logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] mid,
		logic [CFG_DATA_W-1:0] hi);
		write_reg(REG_SEED, 64'(sd));
		write_reg(REG_REGION_COUNT, 64'(cnt));
		write_reg(REG_BACKGROUND, 64'(bg));
		write_reg(REG_PAL_LOW, lo);
		write_reg(REG_PAL_MID, mid);
		write_reg(REG_PAL_HIGH, hi);
	endtask

	task automatic await_results();
		req_ch.valid = 1'b0;
		if (expected_pixels.size() != 0) begin
			while (expected_pixels.size() != 0) @(posedge clk);
			@(negedge clk);
		end
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic test_after_reset();
		send_item(CMD_PIXEL, 16'd0);
		send_item(CMD_PIXEL, 16'd1);
		send_item(CMD_FRAME, 16'd0);
		send_item(CMD_UNUSED, 16'hFFFF);
		send_item(CMD_RESEED, 16'h5A5A);
	endtask

	task automatic test_full_palette();
		await_results();
		program_all(48'hFFFF_FFFF_FFFF, 13'd4096, 24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			rand64(), rand64());
		send_item(CMD_RESEED, 16'd0);
		send_item(CMD_FRAME, 16'd0);
		send_item(CMD_PIXEL, 16'd1);
		send_item(CMD_PIXEL, 16'd4096);
		send_item(CMD_PIXEL, 16'd4097);
		send_item(CMD_PIXEL, 16'hFFFF);
		send_item(CMD_PIXEL, 16'd0);
		send_item(CMD_PIXEL, 16'($urandom_range(2, 4095)));
	endtask

	task automatic test_count_saturation();
		await_results();
		program_all(48'h0, 13'h1FFF, 24'h0, 64'h0, rand64(), 64'h0);
		send_item(CMD_FRAME, 16'd0);
		send_item(CMD_PIXEL, 16'd4096);
		send_item(CMD_PIXEL, 16'd4097);
		send_item(CMD_PIXEL, 16'd8191);
	endtask

	task automatic test_empty_frame();
		await_results();
		write_reg(REG_REGION_COUNT, 64'd0);
		send_item(CMD_FRAME, 16'd0);
		send_item(CMD_PIXEL, 16'd1);
		await_results();
		write_reg(REG_REGION_COUNT, 64'd3);
		send_item(CMD_FRAME, 16'd0);
		send_item(CMD_PIXEL, 16'd3);
		send_item(CMD_PIXEL, 16'd4);
	endtask

	task automatic test_random_traffic();
		int cnt, sel;
		logic [STATE_W-1:0] sd;
		logic [RGB_W-1:0] bg;
		logic [CFG_DATA_W-1:0] lo, mid, hi;
		for (int p = 0; p < 8; p++) begin
			await_results();
			steady_flow = (p == 3);
			case (p)
				0: cnt = 0;
				1: cnt = 1;
				7: cnt = 200;
				default: cnt = $urandom_range(2, 48);
			endcase
			sd = STATE_W'(rand64());
			bg = RGB_W'($urandom);
			lo = rand64();
			mid = rand64();
			hi = rand64();
			if (p == 0) begin
				sd = '1;
				bg = '1;
				{lo, mid, hi} = '1;
			end else if (p == 1) begin
				sd = '0;
				bg = '0;
				{lo, mid, hi} = '0;
			end
			program_all(sd, 13'(cnt), bg, lo, mid, hi);
			send_item(CMD_RESEED, 16'($urandom));
			send_item(CMD_FRAME, 16'($urandom));
			for (int i = 2; i < 100; i++) begin
				sel = $urandom_range(0, 99);
				if (sel < 72)
					send_item(CMD_PIXEL, pick_label());
				else if (sel < 84)
					send_item(CMD_FRAME, 16'($urandom));
				else if (sel < 94)
					send_item(CMD_RESEED, 16'($urandom));
				else
					send_item(CMD_UNUSED, 16'($urandom));
			end
		end
		steady_flow = 1'b0;
	endtask

	task automatic test_backpressure();
		await_results();
		write_reg(REG_REGION_COUNT, 64'd12);
		send_item(CMD_FRAME, 16'd0);
		rsp_hold_cycles = 400;
		for (int i = 0; i < 40; i++)
			send_item((i % 10 == 5) ? CMD_FRAME : CMD_PIXEL, pick_label());
		await_results();
	endtask

	// receiver: random hold-off per transaction, long hold when requested
	initial begin
		int n;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rsp_hold_cycles > 0) begin
				n = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else begin
				n = steady_flow ? 0 : $urandom_range(0, 15);
			end
			if (n > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (n) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			@(posedge clk);
			while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		res_t got, want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.red = rsp_ch.red;
			got.green = rsp_ch.green;
			got.blue = rsp_ch.blue;
			got.alpha = rsp_ch.alpha;
			got.last_draw = rsp_ch.last_draw;
			got.label_error = rsp_ch.label_error;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result r=%h g=%h b=%h a=%h draw=%0d err=%0b",
					$time, got.red, got.green, got.blue, got.alpha, got.last_draw,
					got.label_error);
			end else begin
				want = expected_pixels.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: mismatch expected r=%h g=%h b=%h a=%h draw=%0d err=%0b",
						$time, want.red, want.green, want.blue, want.alpha, want.last_draw,
						want.label_error);
					$display("%0t:          actual r=%h g=%h b=%h a=%h draw=%0d err=%0b",
						$time, got.red, got.green, got.blue, got.alpha, got.last_draw,
						got.label_error);
				end
			end
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_PIXEL;
		req_ch.label = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SEED;
		cfg_ch.data = '0;
		seed_reg = '0;
		count_reg = '0;
		bg_reg = '0;
		pal_lo = '0;
		pal_mid = '0;
		pal_hi = '0;
		gen_state = '0;
		recent_draw = '0;
		drawn_regions = 0;
		mismatches = 0;
		rsp_hold_cycles = 0;
		steady_flow = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_after_reset();
		test_full_palette();
		test_count_saturation();
		test_empty_frame();
		test_random_traffic();
		test_backpressure();

		await_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
